FILE: sv/assert_macros.svh
// Assertion macros for the steering angle block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// ante implies cons on the same edge
`define ASA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// ante implies cons on the next edge
`define ASA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/asa_pkg.sv
package asa_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_MAX_RADIUS = 3'd0,
        REG_MIN_RADIUS = 3'd1,
        REG_FRONT_ARM  = 3'd2,
        REG_BACK_ARM   = 3'd3,
        REG_HALF_TRACK = 3'd4,
        REG_DEAD_ZONE  = 3'd5
    } t_reg_idx;

    localparam logic [14:0] STRAIGHT_RADIUS = 15'd32766;
    localparam logic [7:0]  ANGLE_MIN       = 8'd45;
    localparam logic [7:0]  ANGLE_MAX       = 8'd150;
    localparam logic [7:0]  CENTER_FR       = 8'd98;
    localparam logic [7:0]  CENTER_BR       = 8'd95;
    localparam logic [7:0]  CENTER_FL       = 8'd90;
    localparam logic [7:0]  CENTER_BL       = 8'd103;
    localparam logic [6:0]  OFFSET_SAT      = 7'd90;
    // ceil(2^31 / 255): exact quotient for products below 2^24
    localparam logic [23:0] RECIP_255       = 24'd8421505;
    localparam int          RECIP_SHIFT     = 31;
    localparam int          QDEPTH          = 4;
    localparam int          QAW             = 2;

    // one classified stick sample
    typedef struct packed {
        logic               cen;
        logic               left;
        logic [14:0]        radius;
        logic signed [16:0] rout;
        logic signed [16:0] rin;
    } t_job;

    // sideband carried beside the lanes
    typedef struct packed {
        logic        cen;
        logic        left;
        logic [14:0] radius;
    } t_side;

    // atan(2^-i) in units of 2^-24 degree
    function automatic logic [31:0] f_atan(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd754974720;
            1:  v = 32'd445687602;
            2:  v = 32'd235489088;
            3:  v = 32'd119537938;
            4:  v = 32'd60000934;
            5:  v = 32'd30029717;
            6:  v = 32'd15018523;
            7:  v = 32'd7509720;
            8:  v = 32'd3754917;
            9:  v = 32'd1877466;
            10: v = 32'd938734;
            11: v = 32'd469367;
            12: v = 32'd234684;
            13: v = 32'd117342;
            14: v = 32'd58671;
            15: v = 32'd29335;
            16: v = 32'd14668;
            17: v = 32'd7334;
            18: v = 32'd3667;
            19: v = 32'd1833;
            20: v = 32'd917;
            21: v = 32'd458;
            22: v = 32'd229;
            23: v = 32'd115;
            24: v = 32'd57;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/asa_front.sv
module asa_front
    import asa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic signed [8:0] i_stick_x,
    input  logic [14:0]       i_max_radius,
    input  logic [14:0]       i_min_radius,
    input  logic [11:0]       i_half_track,
    input  logic [7:0]        i_dead_zone,
    input  logic              i_q_full,
    output logic              o_stall,
    output logic              o_q_push,
    output t_job              o_q_job
);

    logic        r_v1, r_v2, r_v3, r_v4;
    logic        r_cen1, r_cen2, r_cen3, r_cen4;
    logic        r_left1, r_left2, r_left3, r_left4;
    logic [7:0]  r_mag1;
    logic [22:0] r_prod2;
    logic [14:0] r_q3;
    t_job        r_job4;
    logic        en;
    logic [9:0]  mag;
    logic [9:0]  x_ext;
    logic        dir_down;
    logic [14:0] diff;
    logic [46:0] recip_prod;
    logic [14:0] radius;

    // advance unless the last stage holds an item the queue cannot take
    assign en       = !(r_v4 && i_q_full);
    assign o_stall  = !en;
    assign o_q_push = r_v4 && !i_q_full;
    assign o_q_job  = r_job4;

    // magnitude of the stick sample
    assign x_ext = {i_stick_x[8], i_stick_x};
    assign mag   = i_stick_x[8] ? (~x_ext + 10'd1) : x_ext;

    // radius span between the two registers
    assign dir_down   = i_max_radius >= i_min_radius;
    assign diff       = dir_down ? (i_max_radius - i_min_radius)
                                 : (i_min_radius - i_max_radius);
    assign recip_prod = r_prod2 * RECIP_255;
    assign radius     = dir_down ? (i_max_radius - r_q3) : (i_max_radius + r_q3);

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // classify, scale, divide by 255, form the radii
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cen1  <= mag <= {2'b00, i_dead_zone};
            r_left1 <= i_stick_x[8];
            r_mag1  <= (mag > 10'd255) ? 8'd255 : mag[7:0];
            r_cen2  <= r_cen1;
            r_left2 <= r_left1;
            r_prod2 <= r_mag1 * diff;
            r_cen3  <= r_cen2;
            r_left3 <= r_left2;
            r_q3    <= recip_prod[RECIP_SHIFT+14:RECIP_SHIFT];
            r_job4.cen    <= r_cen3;
            r_job4.left   <= r_left3;
            r_job4.radius <= r_cen3 ? STRAIGHT_RADIUS : radius;
            r_job4.rout   <= $signed({2'b00, radius}) + $signed({5'b00000, i_half_track});
            r_job4.rin    <= $signed({2'b00, radius}) - $signed({5'b00000, i_half_track});
        end
    end

endmodule

FILE: sv/asa_queue.sv
`include "assert_macros.svh"
module asa_queue
    import asa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job         r_mem [0:QDEPTH-1];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           do_push, do_pop;

    assign o_full  = r_cnt == (QAW+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    // store entries
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

    `ASA_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `ASA_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (QAW+1)'(QDEPTH))
    `ASA_ASSERT_NXT(a_cnt_up, i_clk, i_rst_n, do_push && !do_pop, r_cnt == $past(r_cnt) + 1'b1)

endmodule

FILE: sv/asa_lane.sv
module asa_lane
    import asa_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [11:0]        i_arm,
    input  logic signed [16:0] i_d,
    output logic [6:0]         o_off
);

    localparam int NB   = 12 + FRAC_BITS;
    localparam int XW   = NB + 2;
    localparam int LAST = NB + FRAC_BITS + 1;

    logic [15:0]          r_rem [0:NB];
    logic [NB-1:0]        r_quo [0:NB];
    logic [11:0]          r_arm [0:NB];
    logic [15:0]          r_dv  [0:NB];
    logic                 r_sat [0:LAST];
    logic                 r_zero[0:LAST];
    logic [XW-1:0]        r_x   [1:FRAC_BITS+1];
    logic signed [XW:0]   r_y   [1:FRAC_BITS+1];
    logic signed [31:0]   r_z   [1:FRAC_BITS+1];
    logic signed [32:0]   zr;
    logic [6:0]           r_off;

    // input stage: divisor and dividend
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0]   <= (i_d <= 17'sd0) ? 16'd1 : i_d[15:0];
            r_arm[0]  <= i_arm;
            r_rem[0]  <= '0;
            r_quo[0]  <= '0;
        end
    end

    // flag special cases and delay them alongside the datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= i_arm == 12'd0;
            r_sat[0]  <= i_d <= 17'sd0;
            for (int j = 0; j < LAST; j++) begin
                r_sat[j+1]  <= r_sat[j];
                r_zero[j+1] <= r_zero[j];
            end
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < NB; k++) begin : g_div
        logic        nbit;
        logic [16:0] sh;
        logic        ge;
        if (k < 12) begin : g_a
            assign nbit = r_arm[k][11-k];
        end else begin : g_z
            assign nbit = 1'b0;
        end
        assign sh = {r_rem[k], nbit};
        assign ge = sh >= {1'b0, r_dv[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? 16'(sh - {1'b0, r_dv[k]}) : sh[15:0];
                r_quo[k+1] <= {r_quo[k][NB-2:0], ge};
                r_arm[k+1] <= r_arm[k];
                r_dv[k+1]  <= r_dv[k];
            end
        end
    end

    // vectoring CORDIC, one iteration per stage
    for (genvar i = 0; i <= FRAC_BITS; i++) begin : g_cor
        logic [XW-1:0]      xs;
        logic signed [XW:0] ys;
        logic signed [31:0] zs;
        logic [XW-1:0]      m;
        logic [XW-1:0]      xsh;
        if (i == 0) begin : g_first
            assign xs = XW'(1) << FRAC_BITS;
            assign ys = $signed({2'b00, r_quo[NB]});
            assign zs = '0;
        end else begin : g_next
            assign xs = r_x[i];
            assign ys = r_y[i];
            assign zs = r_z[i];
        end
        assign m   = ys[XW] ? XW'(-ys) : XW'(ys);
        assign xsh = xs >> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1] <= xs + (m >> i);
                if (!ys[XW]) begin
                    r_y[i+1] <= ys - $signed({1'b0, xsh});
                    r_z[i+1] <= zs + $signed(f_atan(i));
                end else begin
                    r_y[i+1] <= ys + $signed({1'b0, xsh});
                    r_z[i+1] <= zs - $signed(f_atan(i));
                end
            end
        end
    end

    // round to whole degrees and clamp
    assign zr = 33'(r_z[FRAC_BITS+1]) + 33'sd8388608;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[LAST])
                r_off <= '0;
            else if (r_sat[LAST])
                r_off <= OFFSET_SAT;
            else if (zr[32])
                r_off <= '0;
            else if (zr[31:24] > 8'(OFFSET_SAT))
                r_off <= OFFSET_SAT;
            else
                r_off <= zr[30:24];
        end
    end

    assign o_off = r_off;

endmodule

FILE: sv/asa_back.sv
module asa_back
    import asa_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_job        i_q_job,
    output logic        o_q_pop,
    input  logic [11:0] i_front_arm,
    input  logic [11:0] i_back_arm,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [14:0] o_radius_mm,
    output logic [7:0]  o_angle_front_right,
    output logic [7:0]  o_angle_back_right,
    output logic [7:0]  o_angle_front_left,
    output logic [7:0]  o_angle_back_left,
    output logic        o_write_front_right,
    output logic        o_write_back_right,
    output logic        o_write_front_left,
    output logic        o_write_back_left
);

    localparam int LAT = 2 * FRAC_BITS + 15;

    logic        en;
    logic        r_sv [0:LAT-1];
    t_side       r_sb [0:LAT-1];
    logic [6:0]  of, ob, inf, inb;
    logic        r_ov;
    logic [14:0] r_radius;
    logic [7:0]  r_ang [0:3];
    logic [7:0]  ang   [0:3];

    // the whole back pipeline moves when the output register frees up
    assign en      = !r_ov || i_pop;
    assign o_q_pop = en && !i_q_empty;
    assign o_empty = !r_ov;

    asa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_of (
        .i_clk(i_clk), .i_en(en), .i_arm(i_front_arm), .i_d(i_q_job.rout), .o_off(of));
    asa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_ob (
        .i_clk(i_clk), .i_en(en), .i_arm(i_back_arm), .i_d(i_q_job.rout), .o_off(ob));
    asa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_if (
        .i_clk(i_clk), .i_en(en), .i_arm(i_front_arm), .i_d(i_q_job.rin), .o_off(inf));
    asa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_ib (
        .i_clk(i_clk), .i_en(en), .i_arm(i_back_arm), .i_d(i_q_job.rin), .o_off(inb));

    // valid chain beside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LAT; j++) r_sv[j] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_sv[0] <= o_q_pop;
            for (int j = 1; j < LAT; j++) r_sv[j] <= r_sv[j-1];
            r_ov <= r_sv[LAT-1];
        end
    end

    // sideband beside the lanes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= '{cen: i_q_job.cen, left: i_q_job.left, radius: i_q_job.radius};
            for (int j = 1; j < LAT; j++) r_sb[j] <= r_sb[j-1];
        end
    end

    // apply offsets to the center angles by turn side
    always_comb begin
        if (r_sb[LAT-1].cen) begin
            ang[0] = CENTER_FR;
            ang[1] = CENTER_BR;
            ang[2] = CENTER_FL;
            ang[3] = CENTER_BL;
        end else if (r_sb[LAT-1].left) begin
            ang[0] = CENTER_FR - {1'b0, of};
            ang[1] = CENTER_BR + {1'b0, ob};
            ang[2] = CENTER_FL - {1'b0, inf};
            ang[3] = CENTER_BL + {1'b0, inb};
        end else begin
            ang[0] = CENTER_FR + {1'b0, inf};
            ang[1] = CENTER_BR - {1'b0, inb};
            ang[2] = CENTER_FL + {1'b0, of};
            ang[3] = CENTER_BL - {1'b0, ob};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_radius <= r_sb[LAT-1].radius;
            for (int k = 0; k < 4; k++) r_ang[k] <= ang[k];
        end
    end

    assign o_radius_mm         = r_radius;
    assign o_angle_front_right = r_ang[0];
    assign o_angle_back_right  = r_ang[1];
    assign o_angle_front_left  = r_ang[2];
    assign o_angle_back_left   = r_ang[3];
    assign o_write_front_right = (r_ang[0] > ANGLE_MIN) && (r_ang[0] < ANGLE_MAX);
    assign o_write_back_right  = (r_ang[1] > ANGLE_MIN) && (r_ang[1] < ANGLE_MAX);
    assign o_write_front_left  = (r_ang[2] > ANGLE_MIN) && (r_ang[2] < ANGLE_MAX);
    assign o_write_back_left   = (r_ang[3] > ANGLE_MIN) && (r_ang[3] < ANGLE_MAX);

endmodule

FILE: sv/ackermann_steering_servo_angles_core.sv
// Throughput: one item per cycle while not stalled; the radius pipeline, a four-entry queue
// and four lanes of pipelined divider plus CORDIC each take a new item every cycle, but the
// front stalls when the queue cannot take its item and the back holds until its output is popped.
// Reset: synchronous, active low; empties all pipelines and the queue and loads
// the register defaults.
module ackermann_steering_servo_angles_core
    import asa_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic signed [8:0] i_stick_x,
    output logic              empty,
    input  logic              pop,
    output logic [14:0]       o_radius_mm,
    output logic [7:0]        o_angle_front_right,
    output logic [7:0]        o_angle_back_right,
    output logic [7:0]        o_angle_front_left,
    output logic [7:0]        o_angle_back_left,
    output logic              o_write_front_right,
    output logic              o_write_back_right,
    output logic              o_write_front_left,
    output logic              o_write_back_left,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [14:0] r_max_radius, r_min_radius;
    logic [11:0] r_front_arm, r_back_arm, r_half_track;
    logic [7:0]  r_dead_zone;
    t_reg_idx    idx;
    logic        q_push, q_full, q_pop, q_empty, stall;
    t_job        f_job, q_job;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[4:2]);
    assign full   = stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_radius <= 15'd4000;
            r_min_radius <= 15'd700;
            r_front_arm  <= 12'd300;
            r_back_arm   <= 12'd300;
            r_half_track <= 12'd250;
            r_dead_zone  <= 8'd10;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_MAX_RADIUS: r_max_radius <= pwdata[14:0];
                REG_MIN_RADIUS: r_min_radius <= pwdata[14:0];
                REG_FRONT_ARM:  r_front_arm  <= pwdata[11:0];
                REG_BACK_ARM:   r_back_arm   <= pwdata[11:0];
                REG_HALF_TRACK: r_half_track <= pwdata[11:0];
                REG_DEAD_ZONE:  r_dead_zone  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (idx)
            REG_MAX_RADIUS: prdata = {17'd0, r_max_radius};
            REG_MIN_RADIUS: prdata = {17'd0, r_min_radius};
            REG_FRONT_ARM:  prdata = {20'd0, r_front_arm};
            REG_BACK_ARM:   prdata = {20'd0, r_back_arm};
            REG_HALF_TRACK: prdata = {20'd0, r_half_track};
            REG_DEAD_ZONE:  prdata = {24'd0, r_dead_zone};
            default:        prdata = '0;
        endcase
    end

    asa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_stick_x(i_stick_x),
        .i_max_radius(r_max_radius), .i_min_radius(r_min_radius),
        .i_half_track(r_half_track), .i_dead_zone(r_dead_zone),
        .i_q_full(q_full), .o_stall(stall), .o_q_push(q_push), .o_q_job(f_job));

    asa_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_job(f_job),
        .o_full(q_full), .i_pop(q_pop), .o_empty(q_empty), .o_job(q_job));

    asa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_empty(q_empty), .i_q_job(q_job),
        .o_q_pop(q_pop), .i_front_arm(r_front_arm), .i_back_arm(r_back_arm),
        .i_pop(pop), .o_empty(empty), .o_radius_mm(o_radius_mm),
        .o_angle_front_right(o_angle_front_right), .o_angle_back_right(o_angle_back_right),
        .o_angle_front_left(o_angle_front_left), .o_angle_back_left(o_angle_back_left),
        .o_write_front_right(o_write_front_right), .o_write_back_right(o_write_back_right),
        .o_write_front_left(o_write_front_left), .o_write_back_left(o_write_back_left));

endmodule
